// ===== hdl/dogd_pkg.sv =====
// ----------------------------------------------------------------------------
// dogd_pkg
// Shared constants and types of the DoG scale-space extremum detector.
// ----------------------------------------------------------------------------
package dogd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // fraction bits of the Q9.7 samples
  localparam int FRAC_BITS    = 7;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 10;
  localparam int VALUE_W   = 9;
  localparam int SCALE_W   = 7;
  localparam int ROW_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic [CFG_W-1:0]   RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]   RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR = 7'd1;

  // neighborhood bounds: bit 0 is top row / left column, bit 2 bottom / right
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } clip_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } lane_res_t;

  // candidate results of one item, centre left (a) and centre right (b)
  typedef struct packed {
    logic               hit_a;
    logic               hit_b;
    logic [VALUE_W-1:0] val_a;
    logic [VALUE_W-1:0] val_b;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] row;
    logic [SCALE_W-1:0] scale;
  } cand_t;

endpackage

// ===== hdl/dogd_line_store.sv =====
// ----------------------------------------------------------------------------
// dogd_line_store
// Two banks of line memory holding the sample triples of the two previous rows.
// ----------------------------------------------------------------------------
module dogd_line_store #(
  parameter int MAX_WIDTH   = dogd_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = dogd_pkg::DEF_SAMPLE_BITS,
  parameter int COL_W       = $clog2(MAX_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [COL_W-1:0]         addr_i,
  input  logic                     old_bank_i,
  input  logic [3*SAMPLE_BITS-1:0] wr_data_i,
  output logic [3*SAMPLE_BITS-1:0] rd_old_o,
  output logic [3*SAMPLE_BITS-1:0] rd_prev_o
);
  import dogd_pkg::*;

  localparam int DW = 3 * SAMPLE_BITS;

  logic [DW-1:0] bank0 [MAX_WIDTH];
  logic [DW-1:0] bank1 [MAX_WIDTH];
  logic [DW-1:0] rd0_r;
  logic [DW-1:0] rd1_r;
  logic          sel_r;

  // the row two above lives in the bank being overwritten this row
  always_ff @(posedge clk) begin
    if (wr_en_i && !old_bank_i) begin
      bank0[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd0_r <= bank0[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_i && old_bank_i) begin
      bank1[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd1_r <= bank1[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      sel_r <= old_bank_i;
    end
  end

  assign rd_old_o  = sel_r ? rd1_r : rd0_r;
  assign rd_prev_o = sel_r ? rd0_r : rd1_r;

endmodule

// ===== hdl/dogd_lane.sv =====
// ----------------------------------------------------------------------------
// dogd_lane
// Extremum test of one window centre against its clipped 3x3x3 neighborhood.
// ----------------------------------------------------------------------------
module dogd_lane #(
  parameter int SAMPLE_BITS = dogd_pkg::DEF_SAMPLE_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0] lo_i  [3][3],
  input  logic signed [SAMPLE_BITS-1:0] mid_i [3][3],
  input  logic signed [SAMPLE_BITS-1:0] up_i  [3][3],
  input  dogd_pkg::clip_t               clip_i,
  output dogd_pkg::lane_res_t           res_o
);
  import dogd_pkg::*;

  localparam int TW = SAMPLE_BITS + VALUE_W;
  localparam logic [SAMPLE_BITS-1:0] FRAC_MASK = SAMPLE_BITS'((1 << FRAC_BITS) - 1);
  localparam logic [SAMPLE_BITS-1:0] ONE_INT   = SAMPLE_BITS'(1 << FRAC_BITS);

  logic signed [SAMPLE_BITS-1:0] ctr;
  logic signed [SAMPLE_BITS-1:0] th;
  logic signed [TW-1:0]          t_ext;
  logic                          not_max;
  logic                          not_min;
  logic                          ok;

  always_comb begin
    ctr = mid_i[1][1];
    // truncate toward zero: negative values with a fraction round up
    th = signed'(ctr & ~FRAC_MASK);
    if (ctr[SAMPLE_BITS-1] && ((ctr & FRAC_MASK) != '0)) begin
      th = signed'(th + ONE_INT);
    end
    t_ext = TW'(th) >>> FRAC_BITS;

    not_max = 1'b0;
    not_min = 1'b0;
    ok      = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok = clip_i.row_ok[r] & clip_i.col_ok[c];
        if (ok) begin
          if (!(r == 1 && c == 1)) begin
            if (mid_i[r][c] >= th) not_max = 1'b1;
            if (mid_i[r][c] <= th) not_min = 1'b1;
          end
          if (lo_i[r][c] > th || up_i[r][c] > th) not_max = 1'b1;
          if (lo_i[r][c] < th || up_i[r][c] < th) not_min = 1'b1;
        end
      end
    end

    res_o.hit   = !not_max || !not_min;
    res_o.value = t_ext[VALUE_W-1:0];
  end

endmodule

// ===== hdl/dogd_merge.sv =====
// ----------------------------------------------------------------------------
// dogd_merge
// Merges the two lane results of an item into output words, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module dogd_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_i,
  input  dogd_pkg::cand_t                cand_i,
  input  logic                           out_stall,
  output logic                           open_o,
  output logic                           out_valid,
  output logic [dogd_pkg::COORD_W-1:0]   out_center_col,
  output logic [dogd_pkg::COORD_W-1:0]   out_center_row,
  output logic signed [dogd_pkg::VALUE_W-1:0] out_center_value,
  output logic [dogd_pkg::SCALE_W-1:0]   out_octave_scale,
  output logic                           out_last_of_run
);
  import dogd_pkg::*;

  logic               pend_a_r;
  logic               pend_b_r;
  cand_t              cand_r;
  logic               ov_r;
  logic [COORD_W-1:0] ocol_r;
  logic [COORD_W-1:0] orow_r;
  logic [VALUE_W-1:0] oval_r;
  logic [SCALE_W-1:0] oscale_r;
  logic               olast_r;
  logic               take;
  logic               emit;

  assign take   = !ov_r || !out_stall;
  assign emit   = take && (pend_a_r || pend_b_r);
  assign open_o = !(pend_a_r || pend_b_r) || (take && !(pend_a_r && pend_b_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_a_r <= 1'b0;
      pend_b_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (load_i) begin
        pend_a_r <= cand_i.hit_a;
        pend_b_r <= cand_i.hit_b;
      end else if (emit) begin
        if (pend_a_r) pend_a_r <= 1'b0;
        else          pend_b_r <= 1'b0;
      end
      if (take) begin
        ov_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      cand_r <= cand_i;
    end
    if (emit) begin
      orow_r   <= cand_r.row;
      oscale_r <= cand_r.scale;
      if (pend_a_r) begin
        ocol_r  <= cand_r.col_a;
        oval_r  <= cand_r.val_a;
        olast_r <= !pend_b_r;
      end else begin
        ocol_r  <= cand_r.col_b;
        oval_r  <= cand_r.val_b;
        olast_r <= 1'b1;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_center_col   = ocol_r;
  assign out_center_row   = orow_r;
  assign out_center_value = signed'(oval_r);
  assign out_octave_scale = oscale_r;
  assign out_last_of_run  = olast_r;

endmodule

// ===== hdl/dog_scale_space_extremum_detector.sv =====
// ----------------------------------------------------------------------------
// dog_scale_space_extremum_detector
// 3x3x3 scale-space extremum detection over a raster stream of DoG triples.
// Throughput: one word per cycle while out_stall is low; a word with two extrema
// holds the pipe, since the output register drains one result per cycle.
// Reset: counters to zero, registers to 640 x 480 scale 1; the line memory
// is not cleared and no clearing pass runs, so words are taken at once.
// ----------------------------------------------------------------------------
module dog_scale_space_extremum_detector #(
  parameter int MAX_WIDTH   = dogd_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = dogd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [dogd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dogd_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_lower_sample,
  input  logic signed [SAMPLE_BITS-1:0]        in_middle_sample,
  input  logic signed [SAMPLE_BITS-1:0]        in_upper_sample,
  input  logic                                 in_drain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dogd_pkg::COORD_W-1:0]         out_center_col,
  output logic [dogd_pkg::COORD_W-1:0]         out_center_row,
  output logic signed [dogd_pkg::VALUE_W-1:0]  out_center_value,
  output logic [dogd_pkg::SCALE_W-1:0]         out_octave_scale,
  output logic                                 out_last_of_run
);
  import dogd_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  // configuration
  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [SCALE_W-1:0] scale_r;

  // position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;

  // entry stage
  logic [CW-1:0]      w_ext;
  logic [CW-1:0]      w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic               wrap0;
  logic [COL_W-1:0]   c0;
  logic [CW-1:0]      c0x;
  logic [CW-1:0]      c_inc;
  logic [CW-1:0]      cm1;
  logic [ROW_W-1:0]   r_tmp;
  logic [ROW_W-1:0]   r0;
  logic [ROW_W-1:0]   r_inc;
  logic [ROW_W-1:0]   rm1;
  logic               draining;
  logic               ignore;
  logic               acc;
  logic               load1;
  logic               en_a0;
  logic               en_b0;
  clip_t              clip_a0;
  clip_t              clip_b0;

  // stage 1
  logic               v1_r;
  logic signed [SB-1:0] cur_lo1_r, cur_mid1_r, cur_up1_r;
  logic               en_a1_r, en_b1_r;
  clip_t              clip_a1_r, clip_b1_r;
  logic [COORD_W-1:0] col_a1_r, col_b1_r, row1_r;

  // stage 2: window holds the neighborhood of this stage's item
  logic               v2_r;
  logic               en_a2_r, en_b2_r;
  clip_t              clip_a2_r, clip_b2_r;
  logic [COORD_W-1:0] col_a2_r, col_b2_r, row2_r;
  logic signed [SB-1:0] win_lo_r  [3][3];
  logic signed [SB-1:0] win_mid_r [3][3];
  logic signed [SB-1:0] win_up_r  [3][3];
  logic signed [SB-1:0] lo_b  [3][3];
  logic signed [SB-1:0] mid_b [3][3];
  logic signed [SB-1:0] up_b  [3][3];

  logic [3*SB-1:0]    rd_old;
  logic [3*SB-1:0]    rd_prev;
  lane_res_t          res_a;
  lane_res_t          res_b;
  cand_t              cand;

  logic s3_open, s2_open, s1_open, move1, move2;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      scale_r  <= RST_SCALE_FACTOR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_wr_data;
        REG_SCALE_FACTOR: scale_r  <= cfg_wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline advance
  // --------------------------------------------------------------------------
  assign s2_open  = !v2_r || s3_open;
  assign move2    = v2_r && s3_open;
  assign move1    = v1_r && s2_open;
  assign s1_open  = !v1_r || s2_open;
  assign in_stall = !s1_open;
  assign acc      = in_valid && s1_open;
  assign load1    = acc && !ignore;

  // --------------------------------------------------------------------------
  // entry stage: position, clipping and counter update
  // --------------------------------------------------------------------------
  always_comb begin
    w_ext = CW'(width_r);
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (height_r > ROW_W'(HEIGHT_LIMIT)) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end

    // a size change can leave the counters out of range
    wrap0    = CW'(col_r) >= w_eff;
    c0       = wrap0 ? '0 : col_r;
    r_tmp    = wrap0 ? row_r + ROW_W'(1) : row_r;
    r0       = (r_tmp > h_eff) ? '0 : r_tmp;
    c0x      = CW'(c0);
    draining = (r0 == h_eff);
    ignore   = in_drain && !draining;

    c_inc = c0x + CW'(1);
    r_inc = r0 + ROW_W'(1);
    if (ignore) begin
      col_nxt = c0;
      row_nxt = r0;
    end else if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc > h_eff) ? '0 : r_inc;
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r0;
    end

    en_a0 = (r0 != '0) && (c0x != '0);
    en_b0 = (r0 != '0) && (c0x == w_eff - CW'(1));
    clip_a0.row_ok = {!draining, 1'b1, r0 >= ROW_W'(2)};
    clip_a0.col_ok = {1'b1, 1'b1, c0x >= CW'(2)};
    clip_b0.row_ok = clip_a0.row_ok;
    clip_b0.col_ok = {1'b0, 1'b1, c0x != '0};
    cm1 = c0x - CW'(1);
    rm1 = r0 - ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  dogd_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       (COL_W)
  ) u_line_store (
    .clk        (clk),
    .rd_en_i    (load1),
    .wr_en_i    (load1 && !draining),
    .addr_i     (c0),
    .old_bank_i (r0[0]),
    .wr_data_i  ({in_lower_sample, in_middle_sample, in_upper_sample}),
    .rd_old_o   (rd_old),
    .rd_prev_o  (rd_prev)
  );

  // --------------------------------------------------------------------------
  // stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (load1) begin
      v1_r <= 1'b1;
    end else if (move1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      cur_lo1_r  <= draining ? '0 : in_lower_sample;
      cur_mid1_r <= draining ? '0 : in_middle_sample;
      cur_up1_r  <= draining ? '0 : in_upper_sample;
      en_a1_r    <= en_a0;
      en_b1_r    <= en_b0;
      clip_a1_r  <= clip_a0;
      clip_b1_r  <= clip_b0;
      col_a1_r   <= cm1[COORD_W-1:0];
      col_b1_r   <= c0x[COORD_W-1:0];
      row1_r     <= rm1[COORD_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: window shift
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (move1) begin
      v2_r <= 1'b1;
    end else if (move2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_lo_r[i][j]  <= '0;
          win_mid_r[i][j] <= '0;
          win_up_r[i][j]  <= '0;
        end
      end
    end else if (move1) begin
      for (int i = 0; i < 3; i++) begin
        win_lo_r[i][0]  <= win_lo_r[i][1];
        win_mid_r[i][0] <= win_mid_r[i][1];
        win_up_r[i][0]  <= win_up_r[i][1];
        win_lo_r[i][1]  <= win_lo_r[i][2];
        win_mid_r[i][1] <= win_mid_r[i][2];
        win_up_r[i][1]  <= win_up_r[i][2];
      end
      win_lo_r[0][2]  <= signed'(rd_old[3*SB-1:2*SB]);
      win_mid_r[0][2] <= signed'(rd_old[2*SB-1:SB]);
      win_up_r[0][2]  <= signed'(rd_old[SB-1:0]);
      win_lo_r[1][2]  <= signed'(rd_prev[3*SB-1:2*SB]);
      win_mid_r[1][2] <= signed'(rd_prev[2*SB-1:SB]);
      win_up_r[1][2]  <= signed'(rd_prev[SB-1:0]);
      win_lo_r[2][2]  <= cur_lo1_r;
      win_mid_r[2][2] <= cur_mid1_r;
      win_up_r[2][2]  <= cur_up1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      en_a2_r   <= en_a1_r;
      en_b2_r   <= en_b1_r;
      clip_a2_r <= clip_a1_r;
      clip_b2_r <= clip_b1_r;
      col_a2_r  <= col_a1_r;
      col_b2_r  <= col_b1_r;
      row2_r    <= row1_r;
    end
  end

  // right-hand centre sits in the last window column; its right side is clipped
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_b[i][0]  = win_lo_r[i][1];
      mid_b[i][0] = win_mid_r[i][1];
      up_b[i][0]  = win_up_r[i][1];
      lo_b[i][1]  = win_lo_r[i][2];
      mid_b[i][1] = win_mid_r[i][2];
      up_b[i][1]  = win_up_r[i][2];
      lo_b[i][2]  = win_lo_r[i][2];
      mid_b[i][2] = win_mid_r[i][2];
      up_b[i][2]  = win_up_r[i][2];
    end
  end

  dogd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_a (
    .lo_i   (win_lo_r),
    .mid_i  (win_mid_r),
    .up_i   (win_up_r),
    .clip_i (clip_a2_r),
    .res_o  (res_a)
  );

  dogd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_b (
    .lo_i   (lo_b),
    .mid_i  (mid_b),
    .up_i   (up_b),
    .clip_i (clip_b2_r),
    .res_o  (res_b)
  );

  always_comb begin
    cand.hit_a = en_a2_r && res_a.hit;
    cand.hit_b = en_b2_r && res_b.hit;
    cand.val_a = res_a.value;
    cand.val_b = res_b.value;
    cand.col_a = col_a2_r;
    cand.col_b = col_b2_r;
    cand.row   = row2_r;
    cand.scale = scale_r;
  end

  // --------------------------------------------------------------------------
  // stage 3 and output register
  // --------------------------------------------------------------------------
  dogd_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (move2),
    .cand_i           (cand),
    .out_stall        (out_stall),
    .open_o           (s3_open),
    .out_valid        (out_valid),
    .out_center_col   (out_center_col),
    .out_center_row   (out_center_row),
    .out_center_value (out_center_value),
    .out_octave_scale (out_octave_scale),
    .out_last_of_run  (out_last_of_run)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the first of a pair is followed at once by its right-hand neighbor
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_run) |=>
      (out_valid && out_last_of_run &&
       out_center_col == COORD_W'($past(out_center_col) + COORD_W'(1)) &&
       out_center_row == $past(out_center_row)))
    else $error("second result of a word missing or misplaced");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load1 |=> (CW'(col_r) < $past(w_eff)))
    else $error("column counter beyond image width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load1 |=> (row_r <= $past(h_eff)))
    else $error("row counter beyond drain row");

endmodule
